// ===== design/krss_pkg.sv =====
// Shared constants, widths and the end-of-array summary type for the
// repeated-array maximum subarray sum block. No dependencies.
package krss_pkg;

	localparam int MAX_LEN = 4096;
	localparam int ELEM_W  = 16;
	localparam int REP_W   = 16;
	localparam int OUT_W   = 48;

	// Count saturates one above the length limit to flag an overlong array.
	localparam int CNT_W = $clog2(MAX_LEN + 2);
	// Running sums: element width plus growth over MAX_LEN adds, plus headroom.
	localparam int SUM_W  = ELEM_W + $clog2(MAX_LEN) + 2;
	localparam int BASE_W = SUM_W + 2;
	localparam int PROD_W = SUM_W + REP_W + 1;

	localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_LEN);
	localparam logic [CNT_W-1:0] CNT_OVER  = CNT_W'(MAX_LEN + 1);

	localparam logic [REP_W-1:0] REP_RESET = REP_W'(1);
	localparam logic [REP_W-1:0] REP_ONE   = REP_W'(1);
	localparam logic [REP_W-1:0] REP_TWO   = REP_W'(2);

	localparam logic signed [SUM_W-1:0] SUM_NEG_INIT = {1'b1, {(SUM_W-1){1'b0}}};

	// APB register map: one word register at byte address 0.
	localparam int APB_AW  = 3;
	localparam int APB_DW  = 32;
	localparam int REG_IDX_W = APB_AW - 2;
	localparam logic [REG_IDX_W-1:0] REG_REPEAT_COUNT = REG_IDX_W'(0);

	// Running values captured at the last element of an array.
	typedef struct packed {
		logic signed [SUM_W-1:0] kad_best;
		logic signed [SUM_W-1:0] total;
		logic signed [SUM_W-1:0] best_prefix;
		logic signed [SUM_W-1:0] min_prefix;
		logic                    too_long;
	} krss_snap_t;

endpackage

// ===== design/krss_accum.sv =====
// Input register and per-element running sums (Kadane, prefix, best and
// minimum prefix). Captures a summary at each last element. Uses krss_pkg.
module krss_accum (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       in_valid,
	input  logic [krss_pkg::ELEM_W-1:0] in_element,
	input  logic                       in_last,
	output logic                       snap_valid,
	output krss_pkg::krss_snap_t       snap
);
	import krss_pkg::*;

	logic                    valid_s1;
	logic [ELEM_W-1:0]       element_s1;
	logic                    last_s1;
	logic                    valid_s2;
	krss_snap_t              snap_s2;

	logic signed [SUM_W-1:0] kcur_q, kbest_q, pre_q, bpre_q, minp_q;
	logic [CNT_W-1:0]        cnt_q;

	logic signed [SUM_W-1:0] x;
	logic signed [SUM_W-1:0] kcur_n, kbest_n, pre_n, bpre_n, minp_n, ksum;
	logic [CNT_W-1:0]        cnt_n;
	logic                    counting;
	krss_snap_t              snap_n;

	always_comb begin
		x        = SUM_W'($signed(element_s1));
		counting = cnt_q < CNT_LIMIT;
		ksum     = kcur_q + x;
		if (counting) begin
			minp_n  = (pre_q < minp_q) ? pre_q : minp_q;
			pre_n   = pre_q + x;
			bpre_n  = (pre_n > bpre_q) ? pre_n : bpre_q;
			kbest_n = (ksum > kbest_q) ? ksum : kbest_q;
			kcur_n  = (ksum < 0) ? '0 : ksum;
			cnt_n   = cnt_q + CNT_W'(1);
		end else begin
			minp_n  = minp_q;
			pre_n   = pre_q;
			bpre_n  = bpre_q;
			kbest_n = kbest_q;
			kcur_n  = kcur_q;
			cnt_n   = CNT_OVER;
		end
		snap_n.kad_best    = kbest_n;
		snap_n.total       = pre_n;
		snap_n.best_prefix = bpre_n;
		snap_n.min_prefix  = minp_n;
		snap_n.too_long    = cnt_n > CNT_LIMIT;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			kcur_q   <= '0;
			kbest_q  <= SUM_NEG_INIT;
			pre_q    <= '0;
			bpre_q   <= SUM_NEG_INIT;
			minp_q   <= '0;
			cnt_q    <= '0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1 && last_s1;
			if (valid_s1) begin
				if (last_s1) begin
					kcur_q  <= '0;
					kbest_q <= SUM_NEG_INIT;
					pre_q   <= '0;
					bpre_q  <= SUM_NEG_INIT;
					minp_q  <= '0;
					cnt_q   <= '0;
				end else begin
					kcur_q  <= kcur_n;
					kbest_q <= kbest_n;
					pre_q   <= pre_n;
					bpre_q  <= bpre_n;
					minp_q  <= minp_n;
					cnt_q   <= cnt_n;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			element_s1 <= in_element;
			last_s1    <= in_last;
			snap_s2    <= snap_n;
		end
	end

	assign snap_valid = valid_s2;
	assign snap       = snap_s2;

endmodule

// ===== design/krss_combine.sv =====
// Final result: prefix/suffix join, repeat multiply, then compare against
// the Kadane best into the output register. Uses krss_pkg.
module krss_combine (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        snap_valid,
	input  krss_pkg::krss_snap_t        snap,
	input  logic [krss_pkg::REP_W-1:0]  repeat_count,
	output logic                        out_valid,
	output logic [krss_pkg::OUT_W-1:0]  max_sum,
	output logic                        too_long
);
	import krss_pkg::*;

	logic signed [BASE_W-1:0] base_n, base_s3;
	logic signed [PROD_W-1:0] prod_n, prod_s3;
	logic [REP_W-1:0]         times;
	logic                     use_mul_s3, multi_s3, too_long_s3, valid_s3;
	logic signed [SUM_W-1:0]  kad_s3;

	logic signed [OUT_W-1:0]  cand, kad_w, result;
	logic                     out_valid_q, too_long_q;
	logic [OUT_W-1:0]         max_sum_q;

	always_comb begin
		// Best suffix is the total less the minimum proper prefix.
		base_n = BASE_W'(snap.best_prefix) + BASE_W'(snap.total) - BASE_W'(snap.min_prefix);
		times  = repeat_count - REP_TWO;
		prod_n = PROD_W'(snap.total) * PROD_W'($signed({1'b0, times}));
	end

	always_comb begin
		cand   = use_mul_s3 ? OUT_W'(base_s3) + OUT_W'(prod_s3) : OUT_W'(base_s3);
		kad_w  = OUT_W'(kad_s3);
		result = (multi_s3 && (cand > kad_w)) ? cand : kad_w;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			valid_s3    <= snap_valid;
			out_valid_q <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			base_s3     <= base_n;
			prod_s3     <= prod_n;
			use_mul_s3  <= (snap.total > 0) && (repeat_count > REP_TWO);
			multi_s3    <= repeat_count > REP_ONE;
			kad_s3      <= snap.kad_best;
			too_long_s3 <= snap.too_long;
			max_sum_q   <= result;
			too_long_q  <= too_long_s3;
		end
	end

	assign out_valid = out_valid_q;
	assign max_sum   = max_sum_q;
	assign too_long  = too_long_q;

endmodule

// ===== design/k_repeat_max_subarray_sum.sv =====
// Top level of the repeated-array maximum subarray sum block: stream ports,
// APB register, assertions. Depends on krss_pkg, krss_accum, krss_combine.
//
//  Channel   Direction  Transfer when            Content
//  s_*       in         s_tvalid & s_tready      tdata[15:0] element, tlast ends array
//  m_*       out        m_tvalid & m_tready      tdata[47:0] max_sum, tuser[0] too_long
//  APB       in         psel&penable&pwrite      byte 0: repeat_count[15:0]
//
// One element is taken every clock while the output side keeps up; the
// throughput is set by the combinational running-sum update in krss_accum.
// After its last element is transferred, a result passes the input register,
// running sums, join and multiply, and output register before it leaves.
// The whole pipeline advances together; it stalls only while a result sits
// in the output register and m_tready is low, and bubbles move with it.
// Reset initialises the running sums, clears all valid bits and sets repeat_count to 1.
module k_repeat_max_subarray_sum (
	input  logic                          clk,
	input  logic                          arst_n,
	// Input stream.
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [15:0]                   s_tdata,   // [15:0] element
	input  logic                          s_tlast,
	// Output stream.
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [47:0]                   m_tdata,   // [47:0] max_sum
	output logic [0:0]                    m_tuser,   // [0] too_long
	// Configuration port.
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [krss_pkg::APB_AW-1:0]   paddr,
	input  logic [krss_pkg::APB_DW-1:0]   pwdata,
	output logic [krss_pkg::APB_DW-1:0]   prdata,
	output logic                          pready
);
	import krss_pkg::*;

	logic              en;
	logic [REP_W-1:0]  repeat_q;
	logic              reg_hit;
	logic              snap_valid;
	krss_snap_t        snap;
	logic [OUT_W-1:0]  max_sum;
	logic              too_long;

	// The pipeline moves whenever the output register is empty or drained.
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	// Register file: a single word, written in the APB access phase.
	assign pready  = 1'b1;
	assign reg_hit = paddr[APB_AW-1:2] == REG_REPEAT_COUNT;
	assign prdata  = reg_hit ? APB_DW'(repeat_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			repeat_q <= REP_RESET;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			repeat_q <= pwdata[REP_W-1:0];
		end
	end

	krss_accum u_accum (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.in_valid   (s_tvalid),
		.in_element (s_tdata[ELEM_W-1:0]),
		.in_last    (s_tlast),
		.snap_valid (snap_valid),
		.snap       (snap)
	);

	krss_combine u_combine (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.snap_valid   (snap_valid),
		.snap         (snap),
		.repeat_count (repeat_q),
		.out_valid    (m_tvalid),
		.max_sum      (max_sum),
		.too_long     (too_long)
	);

	assign m_tdata    = max_sum;
	assign m_tuser[0] = too_long;

	// Every prefix is a subarray, so Kadane's best can never fall below it.
	a_kad_ge_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		snap_valid |-> snap.kad_best >= snap.best_prefix)
		else $error("Kadane best below best prefix");

	// The same holds for the best suffix, total minus minimum proper prefix.
	a_kad_ge_suffix: assert property (@(posedge clk) disable iff (!arst_n)
		snap_valid |-> (BASE_W'(snap.kad_best)
			>= BASE_W'(snap.total) - BASE_W'(snap.min_prefix)))
		else $error("Kadane best below best suffix");

	// The empty prefix is always a candidate, so the minimum never exceeds zero.
	a_min_prefix_nonpos: assert property (@(posedge clk) disable iff (!arst_n)
		snap_valid |-> snap.min_prefix <= 0)
		else $error("minimum proper prefix above zero");

	// A stalled result must stay in the output register until taken.
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(max_sum) && $stable(too_long))
		else $error("output changed while stalled");

endmodule

// ===== sim/tb_k_repeat_max_subarray_sum.sv =====
// Self-checking testbench for k_repeat_max_subarray_sum: streams signed arrays,
// predicts each repeated-array maximum sum and compares every output transfer.
// Depends on krss_pkg and the k_repeat_max_subarray_sum RTL.
module tb_k_repeat_max_subarray_sum;

	import krss_pkg::*;

	// Time given to settle after the last expected result has been taken.
	localparam int SETTLE_CYCLES   = 10;
	localparam int WATCHDOG_LIMIT  = 4000;
	localparam int RANDOM_ITEMS    = 700;
	localparam int RANDOM_PHASES   = 8;
	localparam int HOLDOFF_CYCLES  = 300;
	localparam int unsigned ELEM_LIMIT = MAX_LEN;
	localparam int MAX_PRINTED     = 20;

	localparam logic [APB_AW-1:0] REPEAT_COUNT_ADDR = {REG_REPEAT_COUNT, 2'b00};

	localparam logic signed [63:0] SUM_CEILING = 64'sh7FFF_FFFF_FFFF;
	localparam logic signed [63:0] SUM_FLOOR   = -64'sh8000_0000_0000;

	typedef enum int {MIX_FULL, MIX_SMALL, MIX_EXTREME, MIX_POSITIVE} value_mix_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] max_sum;
		logic                    too_long;
	} sum_result_t;

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [15:0]         s_tdata;   // [15:0] element
	logic                s_tlast;
	logic                m_tvalid;
	logic                m_tready;
	logic [47:0]         m_tdata;   // [47:0] max_sum
	logic [0:0]          m_tuser;   // [0] too_long
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [APB_AW-1:0]   paddr;
	logic [APB_DW-1:0]   pwdata;
	logic [APB_DW-1:0]   prdata;
	logic                pready;

	k_repeat_max_subarray_sum dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Running sums of the array in flight, kept the way the block keeps them.
	logic signed [63:0] run_sum;
	logic signed [63:0] best_run;
	logic signed [63:0] total_sum;
	logic signed [63:0] peak_prefix;
	logic signed [63:0] low_prefix;
	int unsigned        elem_cnt;
	logic [REP_W-1:0]   repeat_setting;

	sum_result_t pending_sums[$];

	// Traffic shaping, changed by the tests between phases.
	int  gap_max;
	int  burst_max;
	int  burst_left;
	bit  offering;
	int  ready_stall_pct;
	int  stall_span;
	int  holdoff_left;

	int unsigned errors;
	int unsigned quiet_cycles;
	int unsigned elements_sent;
	int unsigned arrays_done;
	int unsigned overlong_arrays;
	int unsigned results_checked;
	int unsigned input_stall_cycles;
	int unsigned settings_used;

	task automatic flag_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] want);
		if (errors < MAX_PRINTED) begin
			$display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got,
				want);
		end
		errors++;
	endtask

	function automatic void clear_running();
		run_sum     = '0;
		best_run    = SUM_FLOOR;
		total_sum   = '0;
		peak_prefix = SUM_FLOOR;
		low_prefix  = '0;
		elem_cnt    = 0;
	endfunction

	// Best sum over the repeated array, from the sums of one copy.
	function automatic logic signed [63:0] repeated_best();
		logic signed [63:0] joined;
		logic signed [63:0] pick;
		logic signed [63:0] middle_copies;
		if (repeat_setting <= REP_ONE) begin
			return best_run;
		end
		// Best prefix of the first copy joined to the best suffix of the last one.
		joined = peak_prefix + (total_sum - low_prefix);
		pick = joined;
		if (total_sum > 0 && repeat_setting > REP_TWO) begin
			middle_copies = repeat_setting - REP_TWO;
			if (joined >= SUM_CEILING || total_sum > (SUM_CEILING - joined) / middle_copies) begin
				pick = SUM_CEILING;
			end else begin
				pick = joined + total_sum * middle_copies;
			end
		end
		if (pick > SUM_CEILING) begin
			pick = SUM_CEILING;
		end
		return (pick > best_run) ? pick : best_run;
	endfunction

	function automatic void absorb_element(input logic [15:0] raw, input logic ends);
		logic signed [63:0] x;
		logic signed [63:0] best;
		sum_result_t        r;
		if (elem_cnt < ELEM_LIMIT) begin
			x = {{48{raw[15]}}, raw};
			// The minimum prefix only covers lengths up to n-1, so update it first.
			if (total_sum < low_prefix) begin
				low_prefix = total_sum;
			end
			total_sum = total_sum + x;
			if (total_sum > peak_prefix) begin
				peak_prefix = total_sum;
			end
			run_sum = run_sum + x;
			if (run_sum > best_run) begin
				best_run = run_sum;
			end
			if (run_sum < 0) begin
				run_sum = '0;
			end
			elem_cnt++;
		end else begin
			elem_cnt = ELEM_LIMIT + 1;
		end
		if (ends) begin
			best       = repeated_best();
			r.max_sum  = best[OUT_W-1:0];
			r.too_long = (elem_cnt > ELEM_LIMIT);
			pending_sums.push_back(r);
			arrays_done++;
			if (r.too_long) begin
				overlong_arrays++;
			end
			clear_running();
		end
	endfunction

	// Both sides are sampled at the clock edge, before any nonblocking update.
	always @(posedge clk) begin : stream_monitor
		sum_result_t want;
		if (arst_n) begin
			if (s_tvalid && !s_tready) begin
				input_stall_cycles++;
			end
			if (s_tvalid && s_tready) begin
				absorb_element(s_tdata, s_tlast);
				elements_sent++;
			end
			if (m_tvalid && m_tready) begin
				if (pending_sums.size() == 0) begin
					flag_mismatch("unexpected result", 64'(m_tdata), '0);
				end else begin
					want = pending_sums.pop_front();
					if (m_tdata !== want.max_sum) begin
						flag_mismatch("max_sum", 64'(m_tdata), 64'(want.max_sum));
					end
					if (m_tuser[0] !== want.too_long) begin
						flag_mismatch("too_long", 64'(m_tuser), 64'(want.too_long));
					end
					results_checked++;
				end
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
		end
	end

	initial begin : watchdog
		wait (quiet_cycles >= WATCHDOG_LIMIT);
		$display("Watchdog: no transfer for %0d cycles, %0d results outstanding",
			WATCHDOG_LIMIT, pending_sums.size());
		$display("tb_k_repeat_max_subarray_sum NOT OK");
		$finish;
	end

	// Output side: short random stalls, plus a long hold-off on request.
	initial begin : receiver
		int stall_left;
		stall_left = 0;
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (holdoff_left > 0) begin
				m_tready <= 1'b0;
				holdoff_left--;
			end else if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else if (ready_stall_pct != 0 && $urandom_range(99) < ready_stall_pct) begin
				m_tready <= 1'b0;
				stall_left = $urandom_range(0, stall_span);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// All stimulus tasks start and end just after a rising edge.
	task automatic send_element(input logic [15:0] value, input logic ends);
		s_tvalid <= 1'b1;
		s_tdata  <= value;
		s_tlast  <= ends;
		offering = 1'b1;
		do @(posedge clk); while (!s_tready);
		if (gap_max > 0) begin
			if (burst_left == 0) begin
				s_tvalid <= 1'b0;
				offering = 1'b0;
				repeat ($urandom_range(1, gap_max)) @(posedge clk);
				burst_left = $urandom_range(0, burst_max);
			end else begin
				burst_left--;
			end
		end
	endtask

	task automatic send_list(input int vals[$]);
		for (int i = 0; i < vals.size(); i++) begin
			send_element(16'(vals[i]), i == vals.size() - 1);
		end
	endtask

	function automatic logic [15:0] pick_element(input value_mix_t mix);
		case (mix)
			MIX_SMALL: begin
				return 16'($urandom_range(0, 16) - 8);
			end
			MIX_EXTREME: begin
				case ($urandom_range(0, 4))
					0: return 16'h7FFF;
					1: return 16'h8000;
					2: return 16'h0000;
					3: return 16'hFFFF;
					default: return 16'h0001;
				endcase
			end
			MIX_POSITIVE: begin
				return 16'($urandom_range(0, 2000) - 500);
			end
			default: begin
				return 16'($urandom_range(0, 65535));
			end
		endcase
	endfunction

	task automatic send_random_array(input int len, input value_mix_t mix);
		for (int i = 0; i < len; i++) begin
			send_element(pick_element(mix), i == len - 1);
		end
	endtask

	task automatic wait_drained();
		if (offering) begin
			s_tvalid <= 1'b0;
			offering = 1'b0;
		end
		while (pending_sums.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apb_transfer(input logic is_write, input logic [APB_DW-1:0] wdata,
		output logic [APB_DW-1:0] rdata);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= is_write;
		paddr   <= REPEAT_COUNT_ADDR;
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic check_register(input logic [REP_W-1:0] want);
		logic [APB_DW-1:0] rdata;
		apb_transfer(1'b0, '0, rdata);
		if (rdata[REP_W-1:0] !== want) begin
			flag_mismatch("repeat_count readback", 64'(rdata), 64'(want));
		end
	endtask

	// Only called with the block idle; upper write bits are noise the register drops.
	task automatic set_repeat(input logic [REP_W-1:0] value);
		logic [APB_DW-1:0] unused;
		wait_drained();
		apb_transfer(1'b1, {16'($urandom_range(0, 65535)), value}, unused);
		repeat_setting = value;
		settings_used++;
		check_register(value);
	endtask

	task automatic test_register_access();
		check_register(REP_RESET);
		set_repeat(16'hFFFF);
		set_repeat(16'h0000);
		set_repeat(REP_ONE);
	endtask

	// Hand-picked arrays: field extremes, all-negative sets, wrap-around joins,
	// a positive total over the largest repeat, and zero repetitions.
	task automatic test_directed_arrays();
		int vals[$];
		gap_max = 3;
		burst_max = 4;
		ready_stall_pct = 30;
		stall_span = 3;
		set_repeat(REP_ONE);
		vals = '{32767};
		send_list(vals);
		vals = '{-32768};
		send_list(vals);
		vals = '{-7, -2, -9};
		send_list(vals);
		vals = '{3, -4, 5, -1, 2};
		send_list(vals);
		set_repeat(REP_TWO);
		vals = '{5, -20, 6};
		send_list(vals);
		vals = '{-32768, -32768};
		send_list(vals);
		set_repeat(16'hFFFF);
		vals = '{32767, 32767, 32767};
		send_list(vals);
		vals = '{1, -3, 1};
		send_list(vals);
		set_repeat(16'h0000);
		vals = '{4, -9, 4};
		send_list(vals);
	endtask

	// One array a single element past the length limit; that element is ignored
	// but still ends the array with its last marker. A short array follows.
	task automatic test_overlong_arrays();
		gap_max = 0;
		ready_stall_pct = 0;
		set_repeat(16'd3);
		send_random_array(ELEM_LIMIT + 1, MIX_EXTREME);
		send_random_array(3, MIX_SMALL);
	endtask

	// The output side holds off while single-element arrays keep coming, so
	// the pipeline fills and the input has to stall.
	task automatic test_output_holdoff();
		gap_max = 0;
		ready_stall_pct = 0;
		set_repeat(REP_TWO);
		holdoff_left = HOLDOFF_CYCLES;
		for (int i = 0; i < 48; i++) begin
			send_element(pick_element(MIX_FULL), 1'b1);
		end
	endtask

	task automatic test_random_arrays();
		logic [REP_W-1:0] rep_pick;
		int               sent;
		int               len;
		int               roll;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase)
				0: rep_pick = REP_ONE;
				1: rep_pick = REP_TWO;
				2: rep_pick = 16'd3;
				3: rep_pick = 16'hFFFF;
				4: rep_pick = 16'h0000;
				default: rep_pick = 16'($urandom_range(1, 65535));
			endcase
			set_repeat(rep_pick);
			// Every third phase runs at full rate on both sides.
			if (phase % 3 == 1) begin
				gap_max = 0;
				ready_stall_pct = 0;
			end else begin
				gap_max = $urandom_range(1, 6);
				burst_max = $urandom_range(0, 8);
				ready_stall_pct = $urandom_range(10, 50);
				stall_span = $urandom_range(0, 5);
			end
			sent = 0;
			while (sent < RANDOM_ITEMS / RANDOM_PHASES) begin
				roll = $urandom_range(99);
				if (roll < 70) begin
					len = $urandom_range(1, 12);
				end else if (roll < 95) begin
					len = $urandom_range(13, 60);
				end else begin
					len = $urandom_range(61, 250);
				end
				send_random_array(len, value_mix_t'($urandom_range(0, 3)));
				sent += len;
			end
		end
	endtask

	initial begin
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tlast  = 1'b0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		gap_max = 0;
		burst_max = 0;
		burst_left = 0;
		offering = 1'b0;
		ready_stall_pct = 0;
		stall_span = 0;
		holdoff_left = 0;
		errors = 0;
		quiet_cycles = 0;
		elements_sent = 0;
		arrays_done = 0;
		overlong_arrays = 0;
		results_checked = 0;
		input_stall_cycles = 0;
		settings_used = 0;
		repeat_setting = REP_RESET;
		clear_running();
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_register_access();
		test_directed_arrays();
		test_overlong_arrays();
		test_output_holdoff();
		test_random_arrays();
		wait_drained();

		$display("Streamed %0d arrays (%0d elements, %0d past the length limit) under %0d repeat settings.",
			arrays_done, elements_sent, overlong_arrays, settings_used);
		$display("Checked %0d results; the input was held back on %0d cycles.",
			results_checked, input_stall_cycles);
		if (errors == 0) begin
			$display("tb_k_repeat_max_subarray_sum OK");
		end else begin
			$display("tb_k_repeat_max_subarray_sum NOT OK");
		end
		$finish;
	end

endmodule
